// ===== rtl/core/mavg_pkg.sv =====
// Shared types and constants for the two-channel moving average unit.
package mavg_pkg;

   // Fixed field widths
   localparam int SAMPLE_W = 32;
   localparam int CNT_W    = 5;
   localparam int TOTAL_W  = SAMPLE_W + CNT_W;
   localparam int RSP_W    = 40;
   localparam int DIV_CNT_W = $clog2(TOTAL_W);

   // Defaults for the top-level parameters
   localparam int MAX_WINDOW_DEF = 16;
   localparam int CHANNELS_DEF   = 2;
   localparam int WINDOW_RESET   = 5;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_START,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic update;
      logic div_start;
      logic div_step;
      logic load_out;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic div_last;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/mavg_div.sv =====
// Bit-serial signed divider: running total by sample count, truncating toward zero.
module mavg_div
   import mavg_pkg::*;
(
   input  logic                       clock,
   input  logic                       start,
   input  logic                       step,
   input  logic signed [TOTAL_W-1:0]  dividend,
   input  logic [CNT_W-1:0]           divisor,
   output logic signed [SAMPLE_W-1:0] quotient,
   output logic                       last
);

   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [TOTAL_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]     dvs_ff, dvs_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W:0]       trial;
   logic [SAMPLE_W-1:0]  mag;

   // One quotient bit per step, magnitude first, sign applied at the end
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, quo_ff[TOTAL_W-1]};
      if (start) begin
         rem_in = '0;
         quo_in = dividend[TOTAL_W-1] ? TOTAL_W'(-dividend) : TOTAL_W'(dividend);
         dvs_in = divisor;
         neg_in = dividend[TOTAL_W-1];
         cnt_in = '0;
      end else if (step) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[TOTAL_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[TOTAL_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   assign last     = (cnt_ff == DIV_CNT_W'(TOTAL_W - 1));
   assign mag      = quo_ff[SAMPLE_W-1:0];
   assign quotient = neg_ff ? $signed(-mag) : $signed(mag);

endmodule

// ===== rtl/core/mavg_datapath.sv =====
// Datapath: sample store, per-channel totals and positions, divider, result register.
module mavg_datapath
   import mavg_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF,
   parameter int CHANNELS   = CHANNELS_DEF
)(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic                 req_channel,
   input  logic [SAMPLE_W-1:0]  req_sample,
   input  logic                 csr_write,
   input  logic [CNT_W-1:0]     csr_window,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [SAMPLE_W-1:0]  rsp_average,
   output logic [CNT_W-1:0]     rsp_used
);

   localparam int POS_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CMP_W  = (POS_W + 1 > CNT_W) ? POS_W + 1 : CNT_W;
   localparam int ADDR_W = CH_W + POS_W;
   localparam int WIN_RST = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

   // Sample store, no reset: entries are read only after being written
   logic signed [SAMPLE_W-1:0] store_ff [2**ADDR_W];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   // Per-channel state
   logic [POS_W-1:0]          pos_ff   [CHANNELS];
   logic                      full_ff  [CHANNELS];
   logic signed [TOTAL_W-1:0] total_ff [CHANNELS];
   logic [CNT_W-1:0]          window_ff, window_in;

   // Captured request and per-item values
   logic [CH_W-1:0]            ch_ff, ch_in;
   logic signed [SAMPLE_W-1:0] smp_ff;
   logic [CNT_W-1:0]           count_ff, count_in;

   // Result register
   logic                       rsp_valid_ff;
   logic [SAMPLE_W-1:0]        avg_ff;
   logic [CNT_W-1:0]           used_ff;

   logic [CMP_W-1:0]           pos_ext, win_ext, pos_next_ext, wr_ext;
   logic [POS_W-1:0]           pos_eff, pos_new;
   logic                       wrap, full_new;
   logic [ADDR_W-1:0]          addr;
   logic signed [TOTAL_W-1:0]  old_ext, total_new;
   logic signed [SAMPLE_W-1:0] quotient;
   logic                       div_last;

   assign ch_in = (CHANNELS == 1) ? '0 : CH_W'(req_channel);

   // Position handling for the captured channel
   always_comb begin
      win_ext      = CMP_W'(window_ff);
      pos_ext      = CMP_W'(pos_ff[ch_ff]);
      pos_eff      = (pos_ext >= win_ext) ? '0 : pos_ff[ch_ff];
      pos_next_ext = CMP_W'(pos_eff) + 1'b1;
      wrap         = (pos_next_ext >= win_ext);
      pos_new      = wrap ? '0 : pos_next_ext[POS_W-1:0];
      full_new     = full_ff[ch_ff] | wrap;
      count_in     = full_new ? window_ff : pos_next_ext[CNT_W-1:0];
      addr         = {ch_ff, pos_eff};
      old_ext      = full_ff[ch_ff] ? TOTAL_W'(rd_data_ff) : '0;
      total_new    = total_ff[ch_ff] - old_ext + TOTAL_W'(smp_ff);
   end

   // Window register clamp
   always_comb begin
      wr_ext = CMP_W'(csr_window);
      if (wr_ext > CMP_W'(MAX_WINDOW))
         window_in = CNT_W'(MAX_WINDOW);
      else if (csr_window == '0)
         window_in = CNT_W'(1);
      else
         window_in = csr_window;
   end

   // Store: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.update)
         store_ff[addr] <= smp_ff;
      rd_data_ff <= store_ff[addr];
   end

   // Request capture and count
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ch_ff  <= ch_in;
         smp_ff <= req_sample;
      end
      if (cmd.update)
         count_ff <= count_in;
   end

   // Channel state, cleared by reset and by a window write
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= CNT_W'(WIN_RST);
         for (int c = 0; c < CHANNELS; c++) begin
            pos_ff[c]   <= '0;
            full_ff[c]  <= 1'b0;
            total_ff[c] <= '0;
         end
      end else if (csr_write) begin
         window_ff <= window_in;
         for (int c = 0; c < CHANNELS; c++) begin
            pos_ff[c]   <= '0;
            full_ff[c]  <= 1'b0;
            total_ff[c] <= '0;
         end
      end else if (cmd.update) begin
         pos_ff[ch_ff]   <= pos_new;
         full_ff[ch_ff]  <= full_new;
         total_ff[ch_ff] <= total_new;
      end
   end

   mavg_div u_div (
      .clock    (clock),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend (total_ff[ch_ff]),
      .divisor  (count_ff),
      .quotient (quotient),
      .last     (div_last)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.load_out)
         rsp_valid_ff <= 1'b1;
      else if (rsp_tready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         avg_ff  <= quotient;
         used_ff <= count_ff;
      end
   end

   assign status.div_last = div_last;
   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_average     = avg_ff;
   assign rsp_used        = used_ff;

endmodule

// ===== rtl/core/mavg_ctrl.sv =====
// Controller: sequences capture, store update, division and result hand-off.
module mavg_ctrl
   import mavg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_READ;
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_START;
         ST_START:  state_in = ST_DIVIDE;
         ST_DIVIDE: if (status.div_last) state_in = ST_DONE;
         ST_DONE:   if (status.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_READ:   ;
         ST_UPDATE: cmd.update    = 1'b1;
         ST_START:  cmd.div_start = 1'b1;
         ST_DIVIDE: cmd.div_step  = 1'b1;
         ST_DONE:   cmd.load_out  = status.out_free;
         default:   ;
      endcase
   end

endmodule

// ===== rtl/core/two_channel_moving_average_unit.sv =====
// Top level of the two-channel moving average unit.
//
//   Channel  Direction  Payload
//   req_     in         tuser: channel; tdata: sample (Q16.16)
//   rsp_     out        tdata: average (Q16.16), samples_used
//   csr_     in         data: window_size (clamped to 1..MAX_WINDOW)
//
// An accepted request passes through a store read, the total update, divider
// load, 37 divider steps and the result load. The next request can be taken in
// the same cycle that its result becomes valid, while that result waits.
// Reset (synchronous, active high) sets the window to 5 and clears all
// positions, full marks and totals; a window write clears them likewise and is
// taken only while the unit is idle with no request offered.
// A stalled result holds the divider's result in DONE.
module two_channel_moving_average_unit
   import mavg_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF,
   parameter int CHANNELS   = CHANNELS_DEF
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [0:0]       req_tuser,  // [0] channel
   input  logic [31:0]      req_tdata,  // [31:0] sample
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // [31:0] average, [36:32] samples_used, rest zero
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CNT_W-1:0] csr_data    // [4:0] window_size
);

   cmd_type             cmd;
   status_type          status;
   logic [SAMPLE_W-1:0] average;
   logic [CNT_W-1:0]    used;

   // Window writes only while idle, never beside a request
   assign csr_ready = req_tready & ~req_tvalid;

   mavg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mavg_datapath #(
      .MAX_WINDOW (MAX_WINDOW),
      .CHANNELS   (CHANNELS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_channel (req_tuser[0]),
      .req_sample  (req_tdata),
      .csr_write   (csr_valid & csr_ready),
      .csr_window  (csr_data),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_average (average),
      .rsp_used    (used)
   );

   // Pack the result
   assign rsp_tdata = {(RSP_W - SAMPLE_W - CNT_W)'(0), used, average};

endmodule

// ===== bench/two_channel_moving_average_unit_test.sv =====
// Self-checking testbench for the two-channel moving average unit.
`timescale 1ns / 100ps

module two_channel_moving_average_unit_test
   import mavg_pkg::*;
;

   localparam int WINDOW_MAX   = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_WAIT  = 50;   // a little longer than a request takes to reach its result

   // One sample request and one averaged result
   typedef struct {
      logic        channel;
      logic [31:0] sample;
   } sample_request_type;

   typedef struct {
      logic signed [31:0] average;
      logic [4:0]         used;
   } mean_result_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [0:0]       req_tuser  = '0;  // [0] channel
   logic [31:0]      req_tdata  = '0;  // [31:0] sample
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;        // [31:0] average, [36:32] samples_used
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_data   = '0;  // [4:0] window_size

   sample_request_type pending_requests[$];
   mean_result_type    expected_means[$];
   sample_request_type next_req;
   mean_result_type    got_mean;
   int                 failures  = 0;
   int                 cycles    = 0;
   int                 req_gap   = 0;
   int                 rsp_stall = 0;
   bit                 idling_on = 1'b1;

   // Predictor state: per-channel sample store, position, full mark and total
   logic signed [31:0] ch_store [2][WINDOW_MAX];
   int unsigned        ch_pos   [2];
   bit                 ch_full  [2];
   longint             ch_total [2];
   int unsigned        window_len;

   two_channel_moving_average_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // 8 ns clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Clamp the window and clear both channels
   function automatic void apply_window(logic [4:0] value);
      if (value == 0)
         window_len = 1;
      else if (value > WINDOW_MAX)
         window_len = WINDOW_MAX;
      else
         window_len = value;
      for (int c = 0; c < 2; c++) begin
         ch_pos[c]   = 0;
         ch_full[c]  = 1'b0;
         ch_total[c] = 0;
      end
   endfunction

   // Store the sample, update the running total and work out the mean
   function automatic mean_result_type advance_channel_average(logic ch,
                                                               logic signed [31:0] s);
      int unsigned     pos;
      longint          count;
      mean_result_type r;
      pos = ch_pos[ch];
      if (pos >= window_len)
         pos = 0;
      if (ch_full[ch])
         ch_total[ch] -= longint'(ch_store[ch][pos]);
      ch_store[ch][pos] = s;
      ch_total[ch] += longint'(s);
      pos++;
      if (pos >= window_len) begin
         pos = 0;
         ch_full[ch] = 1'b1;
      end
      ch_pos[ch] = pos;
      count = ch_full[ch] ? longint'(window_len) : longint'(pos);
      // longint division truncates toward zero
      r.average = 32'(ch_total[ch] / count);
      r.used    = 5'(count);
      return r;
   endfunction

   function automatic logic [31:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return 32'($urandom_range(0, 400)) - 32'd200;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_request(input logic ch, input logic [31:0] s);
      sample_request_type r;
      r.channel = ch;
      r.sample  = s;
      pending_requests.push_back(r);
   endtask

   // Hold the sender until every expected result is back, then let the unit settle
   task automatic drain_requests();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_means.size() != 0);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_window(input logic [4:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      apply_window(value);
   endtask

   // Request driver: takes items from the pending queue, with random gaps while idling_on is set
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_means.push_back(advance_channel_average(req_tuser[0], req_tdata));
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (idling_on && pending_requests.size() != 0
                         && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(0, 5);
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               next_req = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= next_req.channel;
               req_tdata  <= next_req.sample;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and back-pressure
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_means.size() == 0) begin
               $error("result with no request outstanding: tdata %h", rsp_tdata);
               failures++;
            end else begin
               got_mean = expected_means.pop_front();
               if (rsp_tdata[31:0] !== got_mean.average) begin
                  $error("average: expected %0d, actual %0d",
                         got_mean.average, $signed(rsp_tdata[31:0]));
                  failures++;
               end
               if (rsp_tdata[36:32] !== got_mean.used) begin
                  $error("samples_used: expected %0d, actual %0d",
                         got_mean.used, rsp_tdata[36:32]);
                  failures++;
               end
               if (rsp_tdata[RSP_W-1:37] !== '0) begin
                  $error("padding: expected 0, actual %h", rsp_tdata[RSP_W-1:37]);
                  failures++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_stall = $urandom_range(0, 5);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Stimulus sequence
   initial begin
      logic [4:0] windows [9];
      windows = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd3, 5'd2, 5'd0, 5'd5};
      windows[7] = 5'($urandom_range(0, 31));
      apply_window(5'd5);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: truncation toward zero, full window, wrap, extremes and bit patterns
      queue_request(1'b0, -32'sd3);
      queue_request(1'b0, 32'sd2);
      repeat (5) queue_request(1'b0, 32'h7FFF_FFFF);
      repeat (6) queue_request(1'b1, 32'h8000_0000);
      queue_request(1'b1, 32'hAAAA_AAAA);
      queue_request(1'b1, 32'h5555_5555);
      queue_request(1'b1, 32'hFFFF_FFFF);
      queue_request(1'b1, 32'h0000_0000);
      queue_request(1'b1, 32'h0000_0001);
      queue_request(1'b0, 32'hFFFF_FFFF);
      drain_requests();

      // Random phases over a range of window settings, extremes included
      for (int p = 0; p < 9; p++) begin
         write_window(windows[p]);
         idling_on = (p % 3 != 1) && (p != 8);
         @(negedge clock);
         for (int i = 0; i < 98; i++) begin
            // runs on one channel now and then, so windows fill and wrap
            if (i % 20 < 8)
               queue_request(1'(p), random_sample());
            else
               queue_request(1'($urandom_range(0, 1)), random_sample());
         end
         drain_requests();
      end

      if (failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
